### design/frs_pkg.sv
`default_nettype none

package frs_pkg;

    // ring geometry
    localparam int WINDOW_MAX = 256;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int HELD_W     = ADDR_W + 1;

    // field widths
    localparam int FT_W    = 24;
    localparam int RATE_W  = 28;
    localparam int SUM_W   = RATE_W + ADDR_W;
    localparam int COUNT_W = 32;
    localparam int WL_W    = 9;
    localparam int FLOOR_W = 28;
    localparam int CMP_W   = WL_W + HELD_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FLOOR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FPS_FLOOR = 1'b1;

    // request codes
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // register reset values
    localparam logic [WL_W-1:0]    WL_RESET    = 9'd100;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 28'd3;

    // arithmetic constants
    localparam logic [RATE_W-1:0]  RATE_NUM  = 28'd256000000;
    localparam logic [RATE_W-1:0]  RATE_NONE = {RATE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // shared divider: one quotient bit per cycle
    localparam int DIV_W = FT_W;
    localparam int CNT_W = $clog2(SUM_W + 1);

endpackage

`default_nettype wire

### design/frame_rate_statistics_core.sv
// sequence: a frame sample runs the rate division, the retire-or-grow step, the store
//   step and the window average division on a shared restoring divider that makes one
//   quotient bit per cycle, then waits in hand-over until the output register is free
// input: a request waits for the last result's hand-over; a restart skips the divider
// reset: rst_n is asynchronous and active low; all statistics clear, registers return
//   to window length 100 and floor 3; the rate ring needs no clearing pass
`default_nettype none

module frame_rate_statistics_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [frs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [frs_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [frs_pkg::FT_W-1:0]          frame_time,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [frs_pkg::RATE_W-1:0]             current_fps,
    output logic [frs_pkg::RATE_W-1:0]             min_fps,
    output logic                                   min_seen,
    output logic [frs_pkg::RATE_W-1:0]             max_fps,
    output logic [frs_pkg::RATE_W-1:0]             avg_fps,
    output logic [frs_pkg::COUNT_W-1:0]            frame_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE_DIV,
        ST_SUB,
        ST_ADD,
        ST_AVG_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [frs_pkg::WL_W-1:0]    wl_reg, wl_next;
    logic [frs_pkg::FLOOR_W-1:0] floor_reg, floor_next;

    // statistics
    logic [frs_pkg::ADDR_W-1:0]  slot_reg, slot_next;
    logic [frs_pkg::HELD_W-1:0]  held_reg, held_next;
    logic [frs_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [frs_pkg::RATE_W-1:0]  min_reg, min_next;
    logic [frs_pkg::RATE_W-1:0]  max_reg, max_next;
    logic [frs_pkg::RATE_W-1:0]  avg_reg, avg_next;
    logic [frs_pkg::COUNT_W-1:0] frames_reg, frames_next;

    // per-transaction working state
    logic [frs_pkg::RATE_W-1:0]  rate_reg, rate_next;
    logic                        ft_zero_reg, ft_zero_next;
    logic                        drop_reg, drop_next;
    logic [frs_pkg::ADDR_W-1:0]  old_addr_reg, old_addr_next;

    // divider
    logic [frs_pkg::SUM_W-1:0]   dvd_reg, dvd_next;
    logic [frs_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [frs_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [frs_pkg::DIV_W-1:0]   dsr_reg, dsr_next;
    logic [frs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // output registers
    logic                        out_valid_reg, out_valid_next;
    logic [frs_pkg::RATE_W-1:0]  cur_out_reg, cur_out_next;
    logic [frs_pkg::RATE_W-1:0]  min_out_reg, min_out_next;
    logic                        seen_out_reg, seen_out_next;
    logic [frs_pkg::RATE_W-1:0]  max_out_reg, max_out_next;
    logic [frs_pkg::RATE_W-1:0]  avg_out_reg, avg_out_next;
    logic [frs_pkg::COUNT_W-1:0] cnt_out_reg, cnt_out_next;

    // rate ring
    logic [frs_pkg::RATE_W-1:0]  ring_mem [frs_pkg::WINDOW_MAX];
    logic [frs_pkg::RATE_W-1:0]  old_rate_reg;
    logic                        ring_we;

    // divider step signals
    logic [frs_pkg::DIV_W:0]     shifted;
    logic [frs_pkg::DIV_W+1:0]   trial;
    logic                        borrow;
    logic [frs_pkg::DIV_W-1:0]   rem_step;
    logic [frs_pkg::SUM_W-1:0]   quo_step;

    // effective window
    logic [frs_pkg::CMP_W-1:0]   wl_ext;
    logic [frs_pkg::HELD_W-1:0]  win;

    logic in_fire;
    logic out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign current_fps = cur_out_reg;
    assign min_fps     = min_out_reg;
    assign min_seen    = seen_out_reg;
    assign max_fps     = max_out_reg;
    assign avg_fps     = avg_out_reg;
    assign frame_count = cnt_out_reg;

    // window length clamped to 1..WINDOW_MAX
    always_comb
    begin
        wl_ext = frs_pkg::CMP_W'(wl_reg);
        if (wl_ext == '0)
        begin
            win = frs_pkg::HELD_W'(1);
        end
        else if (wl_ext > frs_pkg::CMP_W'(frs_pkg::WINDOW_MAX))
        begin
            win = frs_pkg::HELD_W'(frs_pkg::WINDOW_MAX);
        end
        else
        begin
            win = wl_ext[frs_pkg::HELD_W-1:0];
        end
    end

    // one restoring division step
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[frs_pkg::SUM_W-1]};
        trial    = {1'b0, shifted} - {2'b00, dsr_reg};
        borrow   = trial[frs_pkg::DIV_W+1];
        rem_step = borrow ? shifted[frs_pkg::DIV_W-1:0] : trial[frs_pkg::DIV_W-1:0];
        quo_step = {quo_reg[frs_pkg::SUM_W-2:0], ~borrow};
    end

    // control and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        wl_next        = wl_reg;
        floor_next     = floor_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        avg_next       = avg_reg;
        frames_next    = frames_reg;
        rate_next      = rate_reg;
        ft_zero_next   = ft_zero_reg;
        drop_next      = drop_reg;
        old_addr_next  = old_addr_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cur_out_next   = cur_out_reg;
        min_out_next   = min_out_reg;
        seen_out_next  = seen_out_reg;
        max_out_next   = max_out_reg;
        avg_out_next   = avg_out_reg;
        cnt_out_next   = cnt_out_reg;
        ring_we        = 1'b0;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                frs_pkg::CFG_WINDOW_LENGTH: wl_next = cfg_data[frs_pkg::WL_W-1:0];
                frs_pkg::CFG_MIN_FPS_FLOOR: floor_next = cfg_data[frs_pkg::FLOOR_W-1:0];
                default: ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == frs_pkg::REQ_RESTART)
                    begin
                        slot_next   = '0;
                        held_next   = '0;
                        sum_next    = '0;
                        min_next    = frs_pkg::RATE_NONE;
                        max_next    = '0;
                        avg_next    = '0;
                        frames_next = '0;
                        rate_next   = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        ft_zero_next  = (frame_time == '0);
                        drop_next     = (held_reg >= win);
                        old_addr_next = slot_reg - held_reg[frs_pkg::ADDR_W-1:0];
                        dvd_next      = {frs_pkg::RATE_NUM, {frs_pkg::ADDR_W{1'b0}}};
                        dsr_next      = frame_time;
                        rem_next      = '0;
                        quo_next      = '0;
                        cnt_next      = frs_pkg::CNT_W'(frs_pkg::RATE_W);
                        state_next    = ST_RATE_DIV;
                    end
                end
            end

            ST_RATE_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                dvd_next = {dvd_reg[frs_pkg::SUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == frs_pkg::CNT_W'(1))
                begin
                    rate_next  = ft_zero_reg ? '0 : quo_step[frs_pkg::RATE_W-1:0];
                    state_next = ST_SUB;
                end
            end

            // retire the oldest rate, or grow the window
            ST_SUB:
            begin
                if (drop_reg)
                begin
                    sum_next = sum_reg - frs_pkg::SUM_W'(old_rate_reg);
                end
                else
                begin
                    held_next = held_reg + 1'b1;
                end
                state_next = ST_ADD;
            end

            // store the new rate, update extremes and start the average
            ST_ADD:
            begin
                ring_we   = 1'b1;
                sum_next  = sum_reg + frs_pkg::SUM_W'(rate_reg);
                slot_next = slot_reg + 1'b1;
                if (frames_reg != frs_pkg::COUNT_MAX)
                begin
                    frames_next = frames_reg + 1'b1;
                end
                if ((rate_reg >= floor_reg) && (rate_reg < min_reg))
                begin
                    min_next = rate_reg;
                end
                if (rate_reg > max_reg)
                begin
                    max_next = rate_reg;
                end
                dvd_next   = sum_next;
                dsr_next   = frs_pkg::DIV_W'(held_reg);
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = frs_pkg::CNT_W'(frs_pkg::SUM_W);
                state_next = ST_AVG_DIV;
            end

            ST_AVG_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                dvd_next = {dvd_reg[frs_pkg::SUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == frs_pkg::CNT_W'(1))
                begin
                    avg_next   = quo_step[frs_pkg::RATE_W-1:0];
                    state_next = ST_DONE;
                end
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cur_out_next   = rate_reg;
                    min_out_next   = min_reg;
                    seen_out_next  = (min_reg != frs_pkg::RATE_NONE);
                    max_out_next   = max_reg;
                    avg_out_next   = avg_reg;
                    cnt_out_next   = frames_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= frs_pkg::WL_RESET;
            floor_reg     <= frs_pkg::FLOOR_RESET;
            slot_reg      <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            min_reg       <= frs_pkg::RATE_NONE;
            max_reg       <= '0;
            avg_reg       <= '0;
            frames_reg    <= '0;
            rate_reg      <= '0;
            ft_zero_reg   <= 1'b0;
            drop_reg      <= 1'b0;
            old_addr_reg  <= '0;
            dvd_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dsr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            cur_out_reg   <= '0;
            min_out_reg   <= '0;
            seen_out_reg  <= 1'b0;
            max_out_reg   <= '0;
            avg_out_reg   <= '0;
            cnt_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            floor_reg     <= floor_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            avg_reg       <= avg_next;
            frames_reg    <= frames_next;
            rate_reg      <= rate_next;
            ft_zero_reg   <= ft_zero_next;
            drop_reg      <= drop_next;
            old_addr_reg  <= old_addr_next;
            dvd_reg       <= dvd_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            dsr_reg       <= dsr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            cur_out_reg   <= cur_out_next;
            min_out_reg   <= min_out_next;
            seen_out_reg  <= seen_out_next;
            max_out_reg   <= max_out_next;
            avg_out_reg   <= avg_out_next;
            cnt_out_reg   <= cnt_out_next;
        end
    end

    // rate ring: one write port, one registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot_reg] <= rate_reg;
        end
        old_rate_reg <= ring_mem[old_addr_reg];
    end

endmodule

`default_nettype wire

### design/frs_checker.sv
`default_nettype none

module frs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              req_type,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [frs_pkg::RATE_W-1:0]        current_fps,
    input wire logic [frs_pkg::RATE_W-1:0]        min_fps,
    input wire logic                              min_seen,
    input wire logic [frs_pkg::RATE_W-1:0]        max_fps,
    input wire logic [frs_pkg::RATE_W-1:0]        avg_fps,
    input wire logic [frs_pkg::COUNT_W-1:0]       frame_count
);

    // a waiting result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current_fps) && $stable(avg_fps)
            && $stable(frame_count))
    else $error("result changed while stalled");

    // seen flag agrees with the minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_seen == (min_fps != frs_pkg::RATE_NONE)))
    else $error("min_seen disagrees with min_fps");

    // the current rate never exceeds the maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_fps >= current_fps))
    else $error("current rate above maximum");

    // no frames means empty statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_count == '0) |-> (max_fps == '0) && (avg_fps == '0)
            && !min_seen)
    else $error("statistics present with zero frame count");

    // a frame sample keeps the block busy into the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == frs_pkg::REQ_SAMPLE) |=> !in_ready)
    else $error("input accepted during divider run");

endmodule

bind frame_rate_statistics_core frs_checker u_frs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .current_fps (current_fps),
    .min_fps     (min_fps),
    .min_seen    (min_seen),
    .max_fps     (max_fps),
    .avg_fps     (avg_fps),
    .frame_count (frame_count)
);

`default_nettype wire
